// ===== design/fm_noise_squelch_defines.svh =====
// Assertion macros used by the squelch top level.
// No dependencies.
`ifndef FM_NOISE_SQUELCH_DEFINES_SVH
`define FM_NOISE_SQUELCH_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FNS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define FNS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fns_pkg.sv =====
// Package for the noise squelch: types, constants and the raised-cosine gain tables.
// No dependencies.
package fns_pkg;

	localparam int RampUpLen = 64;
	localparam int RampDownLen = 64;
	localparam int UpW = $clog2(RampUpLen + 1);
	localparam int DnW = $clog2(RampDownLen + 1);

	typedef enum logic [2:0] {
		MODE_MUTED = 3'd0,
		MODE_RAMP_UP = 3'd1,
		MODE_OPEN = 3'd2,
		MODE_TAIL = 3'd3,
		MODE_RAMP_DOWN = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_AVG,
		ST_TAIL,
		ST_GAIN,
		ST_DONE
	} seq_t;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_UNMUTE = 3'd1,
		REG_TAILLV = 3'd2,
		REG_FCOEF = 3'd3,
		REG_SCOEF = 3'd4,
		REG_DELAY = 3'd5,
		REG_MINTAIL = 3'd6,
		REG_MAXTAIL = 3'd7
	} reg_t;

	typedef struct packed {
		logic start;
		logic busy;
	} unit_ctl_t;

	typedef logic [RampUpLen:0][15:0] up_rom_t;
	typedef logic [RampDownLen:0][15:0] down_rom_t;

	// Restoring long division of non-negative values; used at elaboration only.
	function automatic longint div_u(longint num, longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			if (r >= den) begin
				r = r - den;
				q = q | (64'sd1 <<< b);
			end
		end
		return q;
	endfunction

	// Cosine of pi*k/n in Q30 by a folded Taylor series; used at elaboration.
	function automatic longint cos_q30(longint k, longint n);
		longint kk;
		longint x;
		longint x2;
		longint term;
		longint acc;
		logic neg;
		kk = k;
		neg = 1'b0;
		if (2 * kk > n) begin
			kk = n - kk;
			neg = 1'b1;
		end
		x = div_u(longint'(64'd3373259426 * kk), n);
		x2 = (x * x) >>> 30;
		term = 64'd1073741824;
		acc = 64'd1073741824;
		for (int m = 1; m <= 12; m++) begin
			term = (term * x2) >>> 30;
			term = div_u(term, longint'((2 * m - 1) * (2 * m)));
			if ((m & 1) == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		if (acc > 64'sd1073741824)
			acc = 64'sd1073741824;
		if (acc < -64'sd1073741824)
			acc = -64'sd1073741824;
		return neg ? -acc : acc;
	endfunction

	function automatic logic [15:0] up_gain(logic [UpW-1:0] k);
		longint v;
		v = (64'sd1073741824 - cos_q30(longint'(k), RampUpLen) + 64'sd32768) >>> 16;
		return v[15:0];
	endfunction

	function automatic logic [15:0] down_gain(logic [DnW-1:0] k);
		longint v;
		v = (64'sd1073741824 + cos_q30(longint'(k), RampDownLen) + 64'sd32768) >>> 16;
		return v[15:0];
	endfunction

	function automatic up_rom_t make_up_rom();
		up_rom_t r;
		for (int k = 0; k <= RampUpLen; k++)
			r[k] = up_gain(UpW'(k));
		return r;
	endfunction

	function automatic down_rom_t make_down_rom();
		down_rom_t r;
		for (int k = 0; k <= RampDownLen; k++)
			r[k] = down_gain(DnW'(k));
		return r;
	endfunction

	localparam up_rom_t UpRom = make_up_rom();
	localparam down_rom_t DnRom = make_down_rom();

endpackage

// ===== design/fns_isqrt.sv =====
// Bit-serial integer square root of a 32-bit value, one result bit per cycle.
// Depends on fns_pkg.
module fns_isqrt
	import fns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  unit_ctl_t   ctl,
	input  logic [31:0] radicand,
	output logic        done,
	output logic [16:0] root
);

	logic [33:0] rem_q;
	logic [31:0] val_q;
	logic [16:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [33:0] trial;
	logic [33:0] rem_sh;

	assign rem_sh = {rem_q[31:0], val_q[31:30]};
	assign trial = rem_sh - {15'd0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 5'd1) && !ctl.start;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			val_q <= radicand;
			root_q <= '0;
		end else if (run_q) begin
			val_q <= {val_q[29:0], 2'b00};
			if (!trial[33]) begin
				rem_q <= trial;
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[15:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== design/fns_mac.sv =====
// Shift-and-add multiplier: unsigned 24-bit multiplier digit-serial, 2 bits per cycle.
// Depends on fns_pkg.
module fns_mac
	import fns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  unit_ctl_t   ctl,
	input  logic [41:0] mcand,
	input  logic [23:0] mplier,
	output logic        done,
	output logic [65:0] prod
);

	logic [65:0] acc_q;
	logic [65:0] mc_q;
	logic [23:0] mp_q;
	logic [3:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [65:0] part;

	always_comb begin
		part = '0;
		if (mp_q[0])
			part = part + mc_q;
		if (mp_q[1])
			part = part + {mc_q[64:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == 4'd1) && !ctl.start;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= 4'd12;
			end else if (run_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			mc_q <= {24'd0, mcand};
			mp_q <= mplier;
		end else if (run_q) begin
			acc_q <= acc_q + part;
			mc_q <= {mc_q[63:0], 2'b00};
			mp_q <= {2'b00, mp_q[23:2]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== design/fm_noise_squelch.sv =====
// Noise-operated FM squelch with raised-cosine ramps, top level and sequencer.
// Depends on fns_pkg, fns_isqrt, fns_mac and fm_noise_squelch_defines.svh.
// While enabled, each request runs a square root and then seven serial products, and no
// new request is taken until it is done; when disabled, one request a cycle unless the
// output stalls.
// Reset: asynchronous, active low; registers take their default values and the
// averages restart at 100.0 and 1.0. A waiting result holds off the next request.
`include "fm_noise_squelch_defines.svh"
module fm_noise_squelch
	import fns_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sig_i,
	input  logic signed [15:0] sig_q,
	input  logic signed [15:0] noise_i,
	input  logic signed [15:0] noise_q,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_q,
	output logic [2:0]         squelch_mode
);

	logic        enable_q;
	logic [15:0] unmute_q, taillv_q, fcoef_q, scoef_q;
	logic [19:0] delay_q, mintail_q, maxtail_q;

	seq_t        st_q, st_d;
	logic [2:0]  mode_q;
	logic [19:0] step_q, startup_q;
	logic        ready_q;
	logic [39:0] fast_q, slow_q;
	logic signed [15:0] si_q, sq_q;
	logic signed [15:0] oi_q, oq_q;
	logic        ovalid_q;
	logic [3:0]  op_q;
	logic [16:0] mag_q;
	logic [65:0] acc_q;
	logic [15:0] gain_q;
	logic        gneg_q;
	logic [51:0] tot_q;

	unit_ctl_t   sq_ctl, mac_ctl;
	logic        sq_done, mac_done;
	logic [16:0] sq_root;
	logic [65:0] mac_prod;
	logic [31:0] radicand;
	logic [41:0] mcand;
	logic [23:0] mplier;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			unmute_q <= 16'd29491;
			taillv_q <= 16'd32768;
			fcoef_q <= 16'd65000;
			scoef_q <= 16'd65530;
			delay_q <= 20'd0;
			mintail_q <= 20'd4800;
			maxtail_q <= 20'd48000;
		end else if (cfg_we) begin
			unique case (reg_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_UNMUTE: unmute_q <= cfg_data[15:0];
				REG_TAILLV: taillv_q <= cfg_data[15:0];
				REG_FCOEF: fcoef_q <= cfg_data[15:0];
				REG_SCOEF: scoef_q <= cfg_data[15:0];
				REG_DELAY: delay_q <= cfg_data;
				REG_MINTAIL: mintail_q <= cfg_data;
				REG_MAXTAIL: maxtail_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Products: 0 fast*coef, 1 mag*(1-coef), 2 slow*coef, 3 mag*(1-coef),
	// 4 tail diff*lim, 5 I gain, 6 Q gain.
	logic        tail_neg;
	logic [19:0] tail_abs;
	logic [31:0] lim;
	logic [15:0] idx_gain;
	logic [16:0] fc_c, sc_c;

	assign fc_c = 17'd65536 - {1'b0, fcoef_q};
	assign sc_c = 17'd65536 - {1'b0, scoef_q};
	assign tail_neg = maxtail_q < mintail_q;
	assign tail_abs = tail_neg ? mintail_q - maxtail_q : maxtail_q - mintail_q;
	assign lim = (slow_q > 40'h80000000) ? 32'h80000000 : slow_q[31:0];

	logic signed [15:0] cur_s;
	logic [15:0]        cur_abs;
	assign cur_s = (op_q == 4'd5) ? si_q : sq_q;
	assign cur_abs = cur_s[15] ? 16'(-cur_s) : cur_s;

	always_comb begin
		mcand = '0;
		mplier = '0;
		case (op_q)
			4'd0: begin mcand = {2'b0, fast_q}; mplier = {8'd0, fcoef_q}; end
			4'd1: begin mcand = {9'd0, mag_q, 16'd0}; mplier = {7'd0, fc_c}; end
			4'd2: begin mcand = {2'b0, slow_q}; mplier = {8'd0, scoef_q}; end
			4'd3: begin mcand = {9'd0, mag_q, 16'd0}; mplier = {7'd0, sc_c}; end
			4'd4: begin mcand = {10'd0, lim}; mplier = {4'd0, tail_abs}; end
			default: begin mcand = {26'd0, cur_abs}; mplier = {8'd0, gain_q}; end
		endcase
	end

	always_comb begin
		idx_gain = '0;
		if (mode_q == MODE_RAMP_UP)
			idx_gain = UpRom[step_q <= 20'(RampUpLen) ?
				UpW'(20'(RampUpLen) - step_q) : UpW'(0)];
		else
			idx_gain = DnRom[step_q <= 20'(RampDownLen) ?
				DnW'(20'(RampDownLen) - step_q) : DnW'(0)];
	end

	logic signed [31:0] ni_e, nq_e;
	assign ni_e = 32'(noise_i);
	assign nq_e = 32'(noise_q);
	assign radicand = ni_e * ni_e + nq_e * nq_e;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE) || (ovalid_q && out_stall);

	logic [65:0] sum;
	logic [39:0] newavg;
	assign sum = acc_q + mac_prod;
	assign newavg = sum[55:16];

	logic [51:0] tot;
	logic [51:0] minsh;
	assign minsh = {1'b0, mintail_q, 31'd0};
	assign tot = tail_neg ? minsh - mac_prod[51:0] : minsh + mac_prod[51:0];

	logic [30:0] gprod;
	logic [15:0] gres;
	assign gprod = mac_prod[30:0];
	assign gres = gneg_q ? 16'(-((gprod + 31'd32767) >> 15)) : 16'(gprod >> 15);

	always_comb begin
		st_d = st_q;
		sq_ctl = '0;
		unique case (st_q)
			ST_IDLE: if (accept && enable_q) begin
				st_d = ST_SQRT;
				sq_ctl.start = 1'b1;
			end
			ST_SQRT: if (sq_done) begin
				st_d = ST_AVG;
			end
			ST_AVG: if (op_q == 4'd4) st_d = ST_TAIL;
			ST_TAIL: st_d = ST_GAIN;
			ST_GAIN: if (op_q == 4'd7) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Multiplier launch: one product at a time in ST_AVG and ST_GAIN.
	logic mac_run_q;
	always_comb begin
		mac_ctl = '0;
		mac_ctl.busy = (st_q == ST_AVG);
		if ((st_q == ST_AVG && op_q < 4'd4) || (st_q == ST_GAIN && op_q < 4'd7))
			mac_ctl.start = !mac_run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			mode_q <= MODE_MUTED;
			step_q <= '0;
			startup_q <= '0;
			ready_q <= 1'b0;
			fast_q <= 40'd3276800 << 16;
			slow_q <= 40'd32768 << 16;
			ovalid_q <= 1'b0;
			mac_run_q <= 1'b0;
			op_q <= '0;
		end else begin
			st_q <= st_d;
			if ((accept && !enable_q) || (st_q == ST_GAIN && op_q == 4'd7))
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
			if (mac_ctl.start)
				mac_run_q <= 1'b1;
			else if (mac_done)
				mac_run_q <= 1'b0;
			if (st_q == ST_IDLE)
				op_q <= '0;
			if (st_q == ST_AVG && mac_done) begin
				op_q <= op_q + 4'd1;
				if (op_q == 4'd1) fast_q <= newavg;
				if (op_q == 4'd3) slow_q <= newavg;
			end
			if (st_q == ST_AVG && op_q == 4'd4) begin
				if (!ready_q && startup_q != 20'hFFFFF) begin
					startup_q <= startup_q + 20'd1;
					ready_q <= (startup_q + 20'd1) >= delay_q;
				end else if (startup_q >= delay_q)
					ready_q <= 1'b1;
				op_q <= 4'd4;
			end
			if (st_q == ST_TAIL) op_q <= 4'd4;
			if (st_q == ST_GAIN && mac_done)
				op_q <= op_q + 4'd1;
			if (st_q == ST_GAIN && op_q == 4'd7) begin
				unique case (mode_q)
					MODE_RAMP_UP: begin
						if (step_q == '0) mode_q <= MODE_OPEN;
						step_q <= step_q - 20'd1;
					end
					MODE_OPEN: if (fast_q > {taillv_q, 16'd0}) begin
						mode_q <= MODE_TAIL;
						step_q <= (tail_neg && tot_q[51]) ? '0 : tot_q[50:31];
					end
					MODE_TAIL: begin
						if (fast_q < {unmute_q, 16'd0})
							mode_q <= MODE_OPEN;
						else if (step_q == '0) begin
							mode_q <= MODE_RAMP_DOWN;
							step_q <= 20'(RampDownLen);
						end else
							step_q <= step_q - 20'd1;
					end
					MODE_RAMP_DOWN: begin
						if (step_q == '0) mode_q <= MODE_MUTED;
						step_q <= step_q - 20'd1;
					end
					default: if (fast_q < {unmute_q, 16'd0} && ready_q) begin
						mode_q <= MODE_RAMP_UP;
						step_q <= 20'(RampUpLen);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			si_q <= sig_i;
			sq_q <= sig_q;
			if (!enable_q) begin
				oi_q <= sig_i;
				oq_q <= sig_q;
			end
		end
		if (sq_done)
			mag_q <= sq_root;
		if (st_q == ST_AVG && mac_done)
			acc_q <= (op_q == 4'd0 || op_q == 4'd2) ? mac_prod : '0;
		if (st_q == ST_TAIL) begin
			gain_q <= idx_gain;
			gneg_q <= si_q[15];
		end
		if (st_q == ST_GAIN && mac_done) begin
			if (op_q == 4'd4) begin
				gneg_q <= si_q[15];
				tot_q <= tot;
			end else if (op_q == 4'd5) begin
				oi_q <= gres;
				gneg_q <= sq_q[15];
			end else if (op_q == 4'd6) begin
				oq_q <= gres;
			end
		end
		if (st_q == ST_GAIN && op_q == 4'd7) begin
			if (mode_q != MODE_RAMP_UP && mode_q != MODE_RAMP_DOWN) begin
				if (mode_q == MODE_OPEN || mode_q == MODE_TAIL) begin
					oi_q <= si_q;
					oq_q <= sq_q;
				end else begin
					oi_q <= '0;
					oq_q <= '0;
				end
			end
		end
	end

	fns_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .ctl(sq_ctl), .radicand(radicand),
		.done(sq_done), .root(sq_root)
	);

	fns_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mac_ctl), .mcand(mcand), .mplier(mplier),
		.done(mac_done), .prod(mac_prod)
	);

	assign out_valid = ovalid_q;
	assign out_i = oi_q;
	assign out_q = oq_q;
	assign squelch_mode = mode_q;

	`FNS_ASSERT_IMP(a_busy_stall, st_q != ST_IDLE, in_stall, "input taken while busy")
	`FNS_ASSERT_IMP(a_mode_code, 1'b1, mode_q <= 3'd4, "mode code out of range")
	`FNS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_i),
		"stalled result changed")

endmodule
